@@ rtl/swm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median core
// Port widths, default sizes and the token passed along the cell row.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int MEDIAN_W         = 16;
  localparam int CFG_W            = 13;
  localparam int VALUE_BITS_DEF   = 16;
  localparam int MAX_WINDOW_DEF   = 4096;

  // operation carried by a token moving down the tree levels
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_RANK = 2'd2
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } tok_ctl_t;

endpackage

@@ rtl/swm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell: one level of the value count tree
// Holds the counts of its level, updates one node per token or steers a rank
// token to the left or right child and hands the token to the next level.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int LEVEL    = 1,
  parameter int VB       = 16,
  parameter int CNT_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr_en,
  input  logic [VB-1:0]         clr_addr,
  input  swm_pkg::tok_ctl_t     in_ctl,
  input  logic [VB-1:0]         in_val,
  input  logic [CNT_BITS-1:0]   in_rank,
  output swm_pkg::tok_ctl_t     out_ctl,
  output logic [VB-1:0]         out_val,
  output logic [CNT_BITS-1:0]   out_rank
);
  import swm_pkg::*;

  localparam int DEPTH = 2 ** LEVEL;

  logic [CNT_BITS-1:0] cnt_mem [DEPTH];

  tok_ctl_t            ctl_r;
  logic [VB-1:0]       val_r;
  logic [CNT_BITS-1:0] rank_r;
  logic [LEVEL-1:0]    addr_r;
  logic [CNT_BITS-1:0] cnt_r;

  logic [LEVEL-1:0]    addr_in;
  logic                go_right;
  logic [CNT_BITS-1:0] cnt_nxt;

  // node index at this level: top LEVEL bits of the value or of the path
  assign addr_in = in_val[VB-1 -: LEVEL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, op: OP_ADD};
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= in_val;
    rank_r <= in_rank;
    addr_r <= addr_in;
    cnt_r  <= cnt_mem[addr_in];
    if (clr_en) begin
      cnt_mem[clr_addr[LEVEL-1:0]] <= '0;
    end else if (ctl_r.valid && (ctl_r.op != OP_RANK)) begin
      cnt_mem[addr_r] <= cnt_nxt;
    end
  end

  always_comb begin
    cnt_nxt  = (ctl_r.op == OP_ADD) ? cnt_r + 1'b1 : cnt_r - 1'b1;
    go_right = (ctl_r.op == OP_RANK) && (rank_r > cnt_r);
    out_ctl  = ctl_r;
    out_val  = val_r | (VB'(go_right) << (VB - LEVEL));
    out_rank = go_right ? rank_r - cnt_r : rank_r;
  end

endmodule

@@ rtl/sliding_window_median_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_core: running median over the last W samples
// A row of tree-level cells keeps a count per sample value; a ring holds the
// window so the leaving sample can be taken out again.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | into core | in_valid / in_stall  | in_sample_value
//  out_     | from core | out_valid / out_stall| out_median_value
//  cfg_     | into core | cfg_valid / cfg_ready| cfg_window_length
//
//  one sample is taken at a time; with a full window each sample takes a
//  remove, an insert and a rank descent, each a trip down the cell row, a
//  sample into a filling window only an insert, and the sample that fills
//  it an insert and a rank descent.
//  after reset and after each window length write a clearing pass zeroes
//  the counts; no sample is taken meanwhile.
//  a finished median sits in the output register, so a stalled output only
//  holds the core once a second median is ready.
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
  parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF,
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swm_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [swm_pkg::MEDIAN_W-1:0] out_median_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_window_length
);
  import swm_pkg::*;

  localparam int VB       = VALUE_BITS;
  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
  localparam int PTR_BITS = $clog2(MAX_WINDOW);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REM_GO,
    ST_WAIT_REM,
    ST_INS_GO,
    ST_WAIT_INS,
    ST_WAIT_RANK,
    ST_OUT
  } state_t;

  state_t              state_r;
  logic [VB-1:0]       clr_addr_r;
  logic [WIN_BITS-1:0] w_r;
  logic [PTR_BITS-1:0] ptr_r;
  logic [WIN_BITS-1:0] seen_r;
  logic [VB-1:0]       samp_r;
  logic [VB-1:0]       res_r;
  logic                out_valid_r;
  logic [MEDIAN_W-1:0] out_val_r;
  logic [VB-1:0]       hist_q;
  logic [VB-1:0]       hist_mem [MAX_WINDOW];

  tok_ctl_t            tok_ctl_r;
  logic [VB-1:0]       tok_val_r;
  logic [WIN_BITS-1:0] tok_rank_r;

  tok_ctl_t            ch_ctl  [VB+1];
  logic [VB-1:0]       ch_val  [VB+1];
  logic [WIN_BITS-1:0] ch_rank [VB+1];

  logic [31:0]         cfg_ext;
  logic [31:0]         w_sel;
  logic [WIN_BITS-1:0] ptr_inc;
  logic [PTR_BITS-1:0] ptr_nxt;
  logic [WIN_BITS-1:0] rank_init;
  logic                full;
  logic                in_xfer;
  logic                wave_done;

  assign ch_ctl[0]  = tok_ctl_r;
  assign ch_val[0]  = tok_val_r;
  assign ch_rank[0] = tok_rank_r;

  for (genvar k = 1; k <= VB; k++) begin : g_lvl
    swm_cell #(
      .LEVEL    (k),
      .VB       (VB),
      .CNT_BITS (WIN_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr_en   (state_r == ST_CLEAR),
      .clr_addr (clr_addr_r),
      .in_ctl   (ch_ctl[k-1]),
      .in_val   (ch_val[k-1]),
      .in_rank  (ch_rank[k-1]),
      .out_ctl  (ch_ctl[k]),
      .out_val  (ch_val[k]),
      .out_rank (ch_rank[k])
    );
  end

  // a window length write wins over a sample in the same cycle
  assign in_stall         = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_median_value = out_val_r;
  assign in_xfer          = in_valid && !in_stall;
  assign wave_done        = ch_ctl[VB].valid;
  assign full             = (seen_r >= w_r);

  always_comb begin
    cfg_ext = 32'(cfg_window_length);
    if (cfg_ext == 32'd0) begin
      w_sel = 32'd1;
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      w_sel = 32'(MAX_WINDOW);
    end else begin
      w_sel = cfg_ext;
    end
    ptr_inc   = WIN_BITS'(ptr_r) + 1'b1;
    ptr_nxt   = (ptr_inc >= w_r) ? '0 : ptr_inc[PTR_BITS-1:0];
    rank_init = WIN_BITS'(({1'b0, w_r} + 1'b1) >> 1);
  end

  // ring of the window, read data registered
  always_ff @(posedge clk) begin
    hist_q <= hist_mem[ptr_r];
    if (state_r == ST_INS_GO) begin
      hist_mem[ptr_r] <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      w_r         <= WIN_BITS'(1);
      ptr_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      tok_ctl_r   <= '{valid: 1'b0, op: OP_ADD};
    end else begin
      tok_ctl_r.valid <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        w_r        <= WIN_BITS'(w_sel);
        ptr_r      <= '0;
        seen_r     <= '0;
        clr_addr_r <= '0;
        state_r    <= ST_CLEAR;
      end else begin
        unique case (state_r)
          ST_CLEAR: begin
            clr_addr_r <= clr_addr_r + 1'b1;
            if (&clr_addr_r) begin
              state_r <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_xfer) begin
              samp_r  <= VB'(in_sample_value);
              state_r <= full ? ST_REM_GO : ST_INS_GO;
            end
          end
          ST_REM_GO: begin
            tok_ctl_r <= '{valid: 1'b1, op: OP_SUB};
            tok_val_r <= hist_q;
            state_r   <= ST_WAIT_REM;
          end
          ST_WAIT_REM: begin
            if (wave_done) begin
              state_r <= ST_INS_GO;
            end
          end
          ST_INS_GO: begin
            tok_ctl_r <= '{valid: 1'b1, op: OP_ADD};
            tok_val_r <= samp_r;
            ptr_r     <= ptr_nxt;
            if (!full) begin
              seen_r <= seen_r + 1'b1;
            end
            state_r <= ST_WAIT_INS;
          end
          ST_WAIT_INS: begin
            if (wave_done) begin
              if (full) begin
                tok_ctl_r  <= '{valid: 1'b1, op: OP_RANK};
                tok_val_r  <= '0;
                tok_rank_r <= rank_init;
                state_r    <= ST_WAIT_RANK;
              end else begin
                state_r <= ST_IDLE;
              end
            end
          end
          ST_WAIT_RANK: begin
            if (wave_done) begin
              res_r   <= ch_val[VB];
              state_r <= ST_OUT;
            end
          end
          ST_OUT: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_r <= 1'b1;
              out_val_r   <= MEDIAN_W'(res_r);
              state_r     <= ST_IDLE;
            end
          end
          default: state_r <= ST_CLEAR;
        endcase
      end
    end
  end

endmodule

@@ rtl/swm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker: port level checks of the sliding window median core
// Watches the channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [swm_pkg::SAMPLE_W-1:0] in_sample_value,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [swm_pkg::MEDIAN_W-1:0] out_median_value,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [swm_pkg::CFG_W-1:0]    cfg_window_length
);
  import swm_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_value))
    else $error("stalled median changed");

  // one sample at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken straight after a transfer");

  // a window length write starts the clearing pass
  a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("sample accepted during clearing pass");

  // a median needs the tree walk, never the next cycle
  a_no_quick_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("median appeared one cycle after a sample");

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (.*);

@@ tb/sv/tb_sliding_window_median_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_core: self-checking bench of the running median core
// A count tree and sample ring inside the bench predict each median; results
// are checked in order against the queue of pending medians while both
// channels idle at random and several window lengths are set.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_core;
  import swm_pkg::*;

  localparam int LEAVES      = 1 << VALUE_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 120;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MEDIAN_W-1:0] out_median_value;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_window_length = '0;

  // predictor state
  int unsigned         count_tree [0:2*LEAVES-1];
  logic [SAMPLE_W-1:0] sample_ring [0:MAX_WINDOW_DEF-1];
  int unsigned         ring_slot;
  int unsigned         fill_level;
  int unsigned         win_len;

  logic [MEDIAN_W-1:0] pending_medians [$];
  int unsigned         mismatches = 0;
  int unsigned         medians_checked = 0;
  int unsigned         samples_sent = 0;
  int unsigned         cycles = 0;
  int unsigned         max_gap = 16;
  int unsigned         stall_left = 0;

  always #2 clk = ~clk;

  sliding_window_median_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_value (out_median_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  function automatic void restart_window();
    for (int i = 0; i < 2*LEAVES; i++) count_tree[i] = 0;
    ring_slot  = 0;
    fill_level = 0;
  endfunction

  function automatic void tree_adjust(logic [SAMPLE_W-1:0] v, bit remove);
    int unsigned node;
    node = LEAVES + v;
    while (node >= 1) begin
      if (remove) count_tree[node] = count_tree[node] - 1;
      else count_tree[node] = count_tree[node] + 1;
      node = node >> 1;
    end
  endfunction

  function automatic logic [MEDIAN_W-1:0] rank_value(int unsigned rank);
    int unsigned node;
    node = 1;
    while (node < LEAVES) begin
      if (rank <= count_tree[2*node]) node = 2*node;
      else begin
        rank = rank - count_tree[2*node];
        node = 2*node + 1;
      end
    end
    return MEDIAN_W'(node - LEAVES);
  endfunction

  function automatic void set_window(logic [CFG_W-1:0] w);
    win_len = (w == 0) ? 1 : (w > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : w;
    restart_window();
  endfunction

  // push the sample into the window and, once the window is full, queue the median it produces
  function automatic void predict_median(logic [SAMPLE_W-1:0] v);
    int unsigned slot;
    slot = (ring_slot >= win_len) ? 0 : ring_slot;
    if (fill_level >= win_len) tree_adjust(sample_ring[slot], 1'b1);
    else fill_level++;
    tree_adjust(v, 1'b0);
    sample_ring[slot] = v;
    slot++;
    ring_slot = (slot >= win_len) ? 0 : slot;
    if (fill_level >= win_len) pending_medians.push_back(rank_value((win_len + 1) / 2));
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    do @(posedge clk); while (in_stall);
    predict_median(v);
    samples_sent++;
  endtask

  // drop valid and let every pending median drain, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] w);
    drain();
    cfg_valid         <= 1'b1;
    cfg_window_length <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_window(w);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(3, 0))
      0:       return SAMPLE_W'($urandom_range(7, 0));
      1:       return SAMPLE_W'($urandom_range(65535, 65528));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_default_window();
    logic [SAMPLE_W-1:0] edge_vals [8];
    edge_vals = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8000, 16'h0001,
                  16'h7FFF, 16'hFFFE};
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
  endtask

  task automatic test_zero_length();
    write_window('0);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
  endtask

  task automatic test_even_window();
    logic [SAMPLE_W-1:0] seq [9];
    seq = '{16'h0005, 16'h0005, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
            16'h1234, 16'h1234, 16'h0001};
    write_window(CFG_W'(2));
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // the window never fills here, so no median may come out
  task automatic test_saturated_window();
    write_window({CFG_W{1'b1}});
    max_gap = 1;
    for (int i = 0; i < 30; i++) send_sample(random_sample());
    max_gap = 16;
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] lens [5];
    lens = '{CFG_W'(3), CFG_W'(7), CFG_W'(16), CFG_W'(64), CFG_W'(1)};
    foreach (lens[k]) begin
      write_window(lens[k]);
      for (int i = 0; i < 260; i++) begin
        // bursts with no idling now and then
        if (i % 80 == 40) max_gap = 0;
        if (i % 80 == 60) max_gap = 16;
        send_sample(random_sample());
        if (i == 130) drain();
      end
      max_gap = 16;
    end
  endtask

  // result side idling and checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected median %0d, none pending", out_median_value);
      end else begin
        logic [MEDIAN_W-1:0] want;
        want = pending_medians.pop_front();
        medians_checked++;
        if (out_median_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected %0d, got %0d", want, out_median_value);
        end
      end
      stall_left = $urandom_range(max_gap, 0);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    set_window(CFG_W'(1));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_window();
    test_zero_length();
    test_even_window();
    test_saturated_window();
    test_random_windows();
    drain();
    if (pending_medians.size() != 0) mismatches++;
    $display("sent %0d samples over windows 1, 2, 3, 7, 16, 64 and 4096", samples_sent);
    $display("checked %0d medians, %0d mismatches", medians_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
